>>> hdl/mts_pkg.sv
// Shared types, constants and helpers for the min-tracking stack.
package mts_pkg;

  localparam int DATA_W    = 32;
  localparam int CELL_W    = 34;
  localparam int COUNT_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int DEPTH_DEF = 128;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [CELL_W-1:0] cell_t;
  typedef logic [STATUS_W-1:0]      status_t;

  localparam logic    KIND_PUSH = 1'b0;
  localparam logic    KIND_POP  = 1'b1;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_OVERFLOW  = 2'd1;
  localparam status_t ST_UNDERFLOW = 2'd2;

  localparam data_t EMPTY_READ = '1;

  // sign-extend an element to cell width
  function automatic cell_t to_cell(input data_t v);
    return $signed({{(CELL_W-DATA_W){v[DATA_W-1]}}, v});
  endfunction

  // a cell below the minimum is a marker: the element it stands for is the minimum
  function automatic data_t decode_top(input cell_t c, input data_t m);
    if (c < to_cell(m)) begin
      return m;
    end
    return c[DATA_W-1:0];
  endfunction

endpackage

>>> hdl/min_tracking_stack_core.sv
// Top level of the min-tracking stack: stack RAM, top/min registers, result register.
//
//   channel | direction | ports                                         | handshake
//   --------+-----------+-----------------------------------------------+---------------------
//   in      | input     | in_kind, in_value                             | in_valid / in_ready
//   out     | output    | out_status, out_top_value, out_min_value,     | out_valid / out_ready
//           |           | out_count, out_empty_res                      |
//
// Push, overflow, underflow and a pop that empties the stack: result is registered
//   at the acceptance edge and shows on the next cycle.
// A pop that leaves elements behind: the FSM passes through S_POP, which waits on
//   the stack RAM's registered read of the newly exposed top cell and a free output.
// Reset (rst_n low, synchronous) clears the fill level, minimum, FSM and out_valid.
//   The stack RAM is not cleared; only written cells are ever read.
// A stalled result holds in the output register; in_ready drops until it is taken.
module min_tracking_stack_core #(
  parameter int DEPTH = mts_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic signed [mts_pkg::DATA_W-1:0]   in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mts_pkg::STATUS_W-1:0]        out_status,
  output logic signed [mts_pkg::DATA_W-1:0]   out_top_value,
  output logic signed [mts_pkg::DATA_W-1:0]   out_min_value,
  output logic [mts_pkg::COUNT_W-1:0]         out_count,
  output logic                                out_empty_res
);
  import mts_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;   // waiting on the RAM read of the new top

  logic          state_r, state_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  data_t         min_r, min_nxt;
  cell_t         top_r, top_nxt;     // cached top cell, mirrors RAM[fill-1]

  logic          out_valid_r, out_valid_nxt;
  status_t       status_r, status_nxt;
  data_t         otop_r, otop_nxt;
  data_t         omin_r, omin_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic          empty_r, empty_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  cell_t         ram_wdata;
  logic [CELL_W-1:0] ram_rdata;

  logic  out_free, in_fire;
  cell_t x_cell, new_cell, twice_min;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;

  assign x_cell    = to_cell(in_value);
  assign twice_min = to_cell(min_r) <<< 1;

  mts_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    min_nxt       = min_r;
    top_nxt       = top_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    otop_nxt      = otop_r;
    omin_nxt      = omin_r;
    count_nxt     = count_r;
    empty_nxt     = empty_r;
    ram_we        = 1'b0;
    ram_waddr     = fill_r[AW-1:0];
    ram_wdata     = x_cell;
    ram_re        = 1'b0;
    ram_raddr     = AW'(fill_r - FW'(2));
    new_cell      = x_cell;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          if (in_kind == KIND_PUSH) begin
            if (fill_r >= FW'(DEPTH)) begin
              // full: drop the push, report the stack as it stands
              status_nxt = ST_OVERFLOW;
              otop_nxt   = decode_top(top_r, min_r);
              omin_nxt   = min_r;
              count_nxt  = COUNT_W'(fill_r);
              empty_nxt  = 1'b0;
            end else begin
              if (fill_r == '0) begin
                min_nxt = in_value;
              end else if (x_cell < to_cell(min_r)) begin
                // new minimum: store marker 2x - m
                new_cell = (x_cell <<< 1) - to_cell(min_r);
                min_nxt  = in_value;
              end
              ram_we     = 1'b1;
              ram_wdata  = new_cell;
              top_nxt    = new_cell;
              fill_nxt   = fill_r + FW'(1);
              status_nxt = ST_OK;
              otop_nxt   = decode_top(new_cell, min_nxt);
              omin_nxt   = min_nxt;
              count_nxt  = COUNT_W'(fill_r + FW'(1));
              empty_nxt  = 1'b0;
            end
          end else begin
            if (fill_r == '0) begin
              status_nxt = ST_UNDERFLOW;
              otop_nxt   = EMPTY_READ;
              omin_nxt   = EMPTY_READ;
              count_nxt  = '0;
              empty_nxt  = 1'b1;
            end else begin
              // popping a marker restores the previous minimum 2m - c
              if (top_r < to_cell(min_r)) begin
                min_nxt = DATA_W'(twice_min - top_r);
              end
              fill_nxt   = fill_r - FW'(1);
              status_nxt = ST_OK;
              if (fill_r == FW'(1)) begin
                otop_nxt  = EMPTY_READ;
                omin_nxt  = EMPTY_READ;
                count_nxt = '0;
                empty_nxt = 1'b1;
              end else begin
                // fetch the exposed cell; the result is registered from S_POP
                ram_re        = 1'b1;
                out_valid_nxt = 1'b0;
                state_nxt     = S_POP;
              end
            end
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          top_nxt       = $signed(ram_rdata);
          out_valid_nxt = 1'b1;
          otop_nxt      = decode_top($signed(ram_rdata), min_r);
          omin_nxt      = min_r;
          count_nxt     = COUNT_W'(fill_r);
          empty_nxt     = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      min_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      min_r       <= min_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r    <= top_nxt;
    status_r <= status_nxt;
    otop_r   <= otop_nxt;
    omin_r   <= omin_nxt;
    count_r  <= count_nxt;
    empty_r  <= empty_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_top_value = otop_r;
  assign out_min_value = omin_r;
  assign out_count     = count_r;
  assign out_empty_res = empty_r;

endmodule

>>> hdl/mts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/mts_checker.sv
// Port-level checker for the min-tracking stack, bound to the top level.
module mts_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [mts_pkg::STATUS_W-1:0]       out_status,
  input logic signed [mts_pkg::DATA_W-1:0]  out_top_value,
  input logic signed [mts_pkg::DATA_W-1:0]  out_min_value,
  input logic [mts_pkg::COUNT_W-1:0]        out_count,
  input logic                               out_empty_res
);
  import mts_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_top_value)
      && $stable(out_min_value) && $stable(out_status) && $stable(out_count))
    else $error("stalled result changed");

  // empty stack reads all ones with zero count
  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_count == '0
      && out_top_value == EMPTY_READ && out_min_value == EMPTY_READ)
    else $error("empty result malformed");

  // underflow only happens on an empty stack
  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_UNDERFLOW |-> out_empty_res)
    else $error("underflow on non-empty stack");

  // overflow only on a full, hence non-empty, stack
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OVERFLOW |-> !out_empty_res)
    else $error("overflow on empty stack");

  // top never lies below the minimum
  a_top_ge_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_empty_res |-> out_top_value >= out_min_value)
    else $error("top below minimum");

endmodule

bind min_tracking_stack_core mts_checker u_mts_checker (.*);

>>> sim/tb_top.sv
// Self-checking testbench for min_tracking_stack_core: push/pop items vs. a min-stack predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mts_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam int CLK_HALF    = 6;
  localparam int TAIL_CYCLES = 4;          // result register plus the RAM read on a pop
  localparam int MAX_PRINTS  = 40;
  localparam data_t VAL_MAX  = 32'sh7fffffff;
  localparam data_t VAL_MIN  = 32'sh80000000;

  // one pending input item
  typedef struct packed {
    logic  kind;
    data_t value;
  } stack_op_t;

  // what the stack reports after one item
  typedef struct packed {
    status_t              status;
    data_t                top;
    data_t                min_v;
    logic [COUNT_W-1:0]   count;
    logic                 empty;
  } stack_view_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_kind;
  data_t               in_value;
  logic                out_valid;
  logic                out_ready;
  status_t             out_status;
  data_t               out_top_value;
  data_t               out_min_value;
  logic [COUNT_W-1:0]  out_count;
  logic                out_empty_res;

  min_tracking_stack_core #(
    .DEPTH(STACK_DEPTH)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_top_value(out_top_value),
    .out_min_value(out_min_value),
    .out_count    (out_count),
    .out_empty_res(out_empty_res)
  );

  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the stack cells, fill level and minimum.
  // Cells hold either a plain element or a marker 2*x - m (below the minimum).
  // ---------------------------------------------------------------------------
  cell_t       pred_cells [STACK_DEPTH];
  int unsigned pred_fill;
  longint      pred_min;

  stack_op_t   pending_ops [$];      // items waiting for the driver
  stack_view_t expected_views [$];   // predicted results, oldest first

  int  err_count;
  int  send_idle_pct;
  int  stall_pct;
  bit  in_taken;                     // item accepted at the last rising edge

  // generator-side view of the fill level, used to steer sequences
  int unsigned gen_fill;
  data_t       gen_last;

  // apply one item to the predictor and return what the stack should report
  function automatic stack_view_t apply_stack_op(input logic kind, input data_t v);
    stack_view_t r;
    longint      x;
    longint      c;
    x = v;
    r.status = ST_OK;
    if (kind == KIND_PUSH) begin
      if (pred_fill >= STACK_DEPTH) begin
        r.status = ST_OVERFLOW;
      end else if (pred_fill == 0) begin
        pred_cells[0] = cell_t'(x);
        pred_min      = x;
        pred_fill     = 1;
      end else begin
        // pushing below the minimum leaves a marker that remembers the old minimum
        if (x < pred_min) begin
          pred_cells[pred_fill] = cell_t'(2 * x - pred_min);
          pred_min              = x;
        end else begin
          pred_cells[pred_fill] = cell_t'(x);
        end
        pred_fill++;
      end
    end else begin
      if (pred_fill == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        pred_fill--;
        c = pred_cells[pred_fill];
        // popping a marker brings back the minimum from before its push
        if (c < pred_min) begin
          pred_min = 2 * pred_min - c;
        end
      end
    end
    if (pred_fill == 0) begin
      r.top   = EMPTY_READ;
      r.min_v = EMPTY_READ;
      r.empty = 1'b1;
    end else begin
      c       = pred_cells[pred_fill - 1];
      r.top   = data_t'((c < pred_min) ? pred_min : c);
      r.min_v = data_t'(pred_min);
      r.empty = 1'b0;
    end
    r.count = pred_fill[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (err_count < MAX_PRINTS) begin
      $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers. The generator tracks the fill level so it can aim for
  // full and empty stacks on purpose.
  // ---------------------------------------------------------------------------
  task automatic queue_op(input logic kind, input data_t v);
    stack_op_t op;
    op.kind  = kind;
    op.value = v;
    pending_ops.push_back(op);
    if (kind == KIND_PUSH) begin
      if (gen_fill < STACK_DEPTH) gen_fill++;
      gen_last = v;
    end else if (gen_fill > 0) begin
      gen_fill--;
    end
  endtask

  // mix of extremes, small numbers, descending runs (markers) and raw random words
  function automatic data_t pick_value();
    int unsigned sel;
    sel = $urandom_range(7);
    case (sel)
      0: begin
        case ($urandom_range(3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: return data_t'($urandom_range(100)) - 50;
      3, 4: begin
        if (gen_last < VAL_MIN + 1000) return VAL_MIN;
        return gen_last - data_t'($urandom_range(1000, 1));
      end
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic queue_random_ops(input int n, input int push_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < push_pct) begin
        queue_op(KIND_PUSH, pick_value());
      end else begin
        queue_op(KIND_POP, data_t'($urandom));
      end
    end
  endtask

  // pause the sender until the stack has answered everything queued so far
  task automatic wait_drained();
    while (pending_ops.size() != 0 || in_valid || expected_views.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: inputs change on the falling edge. A held item stays put until the
  // rising edge that accepts it; only then may a new one (or a gap) follow.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_in
    stack_op_t op;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        op        = pending_ops.pop_front();
        in_valid <= 1'b1;
        in_kind  <= op.kind;
        in_value <= op.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes on the rising edge. Prediction runs first
  // so an expectation is always queued before its result could be compared.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_out
    stack_view_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        expected_views.push_back(apply_stack_op(in_kind, in_value));
      end
      if (out_valid && out_ready) begin
        if (expected_views.size() == 0) begin
          report_mismatch("unexpected result, count", out_count, -1);
        end else begin
          want = expected_views.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_top_value !== want.top)
            report_mismatch("top_value", out_top_value, want.top);
          if (out_min_value !== want.min_v)
            report_mismatch("min_value", out_min_value, want.min_v);
          if (out_count !== want.count)
            report_mismatch("count", out_count, want.count);
          if (out_empty_res !== want.empty)
            report_mismatch("empty_res", out_empty_res, want.empty);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: reset, directed items, then four phases of random items with varied idling.
  // The driver and monitor own the channel signals and the predictor state.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    gen_fill      = 0;
    gen_last      = '0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: underflow on empty, extremes, equal-to-min, markers, drain to empty
    queue_op(KIND_POP,  VAL_MAX);
    queue_op(KIND_PUSH, VAL_MAX);
    queue_op(KIND_PUSH, VAL_MAX);       // equal to the minimum: stored plain
    queue_op(KIND_PUSH, VAL_MIN);       // widest marker
    queue_op(KIND_PUSH, VAL_MIN);
    queue_op(KIND_PUSH, '0);
    queue_op(KIND_POP,  '0);
    queue_op(KIND_POP,  '1);
    queue_op(KIND_POP,  VAL_MIN);       // marker pop restores the top value as min
    queue_op(KIND_POP,  '0);
    queue_op(KIND_POP,  '0);            // last element out: empty reads
    queue_op(KIND_POP,  '0);            // underflow
    queue_op(KIND_PUSH, VAL_MIN);
    queue_op(KIND_PUSH, VAL_MAX);
    queue_op(KIND_POP,  '0);
    queue_op(KIND_POP,  '0);
    queue_op(KIND_PUSH, '1);
    queue_op(KIND_PUSH, 32'sd5);
    queue_op(KIND_PUSH, -32'sd7);
    queue_op(KIND_PUSH, -32'sd100);
    queue_op(KIND_PUSH, -32'sd100);
    for (int i = 0; i < 6; i++) queue_op(KIND_POP, data_t'($urandom));
    wait_drained();

    // phase: no idling, growing stack
    queue_random_ops(110, 70);
    wait_drained();

    // phase: sender idles, stack driven to full and pushed past it
    send_idle_pct = 61;
    queue_random_ops(110, 80);
    while (gen_fill < STACK_DEPTH) queue_op(KIND_PUSH, pick_value());
    for (int i = 0; i < 3; i++) queue_op(KIND_PUSH, pick_value());
    wait_drained();

    // phase: receiver stalls, mostly pops
    send_idle_pct = 0;
    stall_pct     = 61;
    queue_random_ops(120, 30);
    wait_drained();

    // phase: both sides idle, drained to empty and popped past it
    send_idle_pct = 33;
    stall_pct     = 33;
    queue_random_ops(120, 25);
    while (gen_fill > 0) queue_op(KIND_POP, data_t'($urandom));
    for (int i = 0; i < 2; i++) queue_op(KIND_POP, data_t'($urandom));
    queue_random_ops(20, 60);
    wait_drained();

    // let any stray result surface
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run with all stalls applied
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
